// ===== design/bdl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded double-ended list: shared package
// Sizes, command and status codes, and the control word that the list
// controller broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package bdl_pkg;

  // Storage sizing.
  localparam int CAPACITY      = 256;
  localparam int ELEMENT_WIDTH = 32;
  localparam int IDX_W         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W         = $clog2(CAPACITY + 1);

  typedef logic [ELEMENT_WIDTH-1:0] elem_t;
  typedef logic [IDX_W-1:0]         idx_t;

  // Command codes on the input channel.
  typedef enum logic [2:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_REM_HEAD = 3'd2,
    CMD_REM_TAIL = 3'd3,
    CMD_RD_INDEX = 3'd4,
    CMD_RD_HEAD  = 3'd5,
    CMD_RD_TAIL  = 3'd6
  } command_e;

  // Status codes on the result channel.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  // Data operation that every cell applies in the same cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN,
    CELL_WRITE
  } cell_op_e;

  // Operation on the read chain that runs alongside the data chain.
  typedef enum logic [1:0] {
    RD_HOLD,
    RD_LOAD,
    RD_SHIFT
  } rd_op_e;

  typedef struct packed {
    cell_op_e op;
    rd_op_e   rd_op;
    idx_t     wr_idx;
    elem_t    wr_data;
  } cell_ctrl_t;

endpackage

// ===== design/bounded_double_ended_list_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded double-ended list: top level
// A row of storage cells with the head element in cell 0, driven by a
// controller that keeps the element count and steps the read chain.
//
//   channel   direction  transfer when     signals
//   command   in         start & !busy     command_i, element_i, position_i
//   result    out        done_o (1 cycle)  read_value_o, status_o, length_o
//
// Inserts, removes, unused codes and failed reads give their result in the
// cycle after the transfer, and a new command may follow at once.
// A successful read loads the read chain, which then moves the element one
// cell per cycle to cell 0, where it is taken as the registered result.
// Reset clears the count and the controller; cell contents are not cleared.
// The receiver cannot stall; busy is high only while a read walks the chain.
// ----------------------------------------------------------------------------
module bounded_double_ended_list_top
  import bdl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command_i,
  input  logic [31:0] element_i,
  input  logic [7:0]  position_i,
  output logic        done_o,
  output logic [31:0] read_value_o,
  output logic [1:0]  status_o,
  output logic [8:0]  length_o
);

  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  idx_t             rd_cnt_q, rd_cnt_d;
  logic             done_q, done_d;
  logic [31:0]      read_value_q, read_value_d;
  status_e          status_q, status_d;
  logic [8:0]       length_q, length_d;

  cell_ctrl_t ctrl;
  elem_t      data_w [CAPACITY];
  elem_t      rd_w   [CAPACITY];

  logic accept;
  logic full;
  logic empty;
  logic pos_ok;

  assign accept = start && (state_q == S_IDLE);
  assign full   = (count_q == CNT_W'(CAPACITY));
  assign empty  = (count_q == '0);
  assign pos_ok = (CMP_W'(position_i) < CMP_W'(count_q));

  // Controller next state and cell control word.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rd_cnt_d     = rd_cnt_q;
    done_d       = 1'b0;
    read_value_d = '0;
    status_d     = ST_OK;
    ctrl.op      = CELL_HOLD;
    ctrl.rd_op   = RD_HOLD;
    ctrl.wr_idx  = idx_t'(count_q);
    ctrl.wr_data = elem_t'(element_i);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          done_d = 1'b1;
          case (command_e'(command_i))
            CMD_INS_HEAD: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                ctrl.op = CELL_SHIFT_UP;
                count_d = count_q + 1'b1;
              end
            end
            CMD_INS_TAIL: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                ctrl.op = CELL_WRITE;
                count_d = count_q + 1'b1;
              end
            end
            CMD_REM_HEAD: begin
              if (!empty) begin
                ctrl.op = CELL_SHIFT_DOWN;
                count_d = count_q - 1'b1;
              end
            end
            CMD_REM_TAIL: begin
              if (!empty) begin
                count_d = count_q - 1'b1;
              end
            end
            CMD_RD_INDEX: begin
              if (pos_ok) begin
                ctrl.rd_op = RD_LOAD;
                rd_cnt_d   = idx_t'(position_i);
                state_d    = S_READ;
                done_d     = 1'b0;
              end else begin
                status_d = ST_MISS;
              end
            end
            CMD_RD_HEAD: begin
              if (!empty) begin
                ctrl.rd_op = RD_LOAD;
                rd_cnt_d   = '0;
                state_d    = S_READ;
                done_d     = 1'b0;
              end else begin
                status_d = ST_MISS;
              end
            end
            CMD_RD_TAIL: begin
              if (!empty) begin
                ctrl.rd_op = RD_LOAD;
                rd_cnt_d   = idx_t'(count_q - 1'b1);
                state_d    = S_READ;
                done_d     = 1'b0;
              end else begin
                status_d = ST_MISS;
              end
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end
      S_READ: begin
        // Walk the read chain until the wanted element sits in cell 0.
        if (rd_cnt_q == '0) begin
          done_d       = 1'b1;
          read_value_d = 32'(rd_w[0]);
          state_d      = S_IDLE;
        end else begin
          ctrl.rd_op = RD_SHIFT;
          rd_cnt_d   = rd_cnt_q - 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    length_d = 9'(count_d);
  end

  // Controller state and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      rd_cnt_q     <= '0;
      done_q       <= 1'b0;
      read_value_q <= '0;
      status_q     <= ST_OK;
      length_q     <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      rd_cnt_q     <= rd_cnt_d;
      done_q       <= done_d;
      read_value_q <= read_value_d;
      status_q     <= status_d;
      length_q     <= length_d;
    end
  end

  // Row of storage cells, head in cell 0.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    elem_t prev_data;
    elem_t next_data;
    elem_t next_rd;

    if (i == 0) begin : g_first
      assign prev_data = ctrl.wr_data;
    end else begin : g_mid_prev
      assign prev_data = data_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_data = '0;
      assign next_rd   = '0;
    end else begin : g_mid_next
      assign next_data = data_w[i+1];
      assign next_rd   = rd_w[i+1];
    end

    bdl_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .idx_i       (idx_t'(i)),
      .prev_data_i (prev_data),
      .next_data_i (next_data),
      .next_rd_i   (next_rd),
      .data_o      (data_w[i]),
      .rd_o        (rd_w[i])
    );
  end

  assign busy         = (state_q == S_READ);
  assign done_o       = done_q;
  assign read_value_o = read_value_q;
  assign status_o     = status_q;
  assign length_o     = length_q;

endmodule

// ===== design/bdl_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded double-ended list: storage cell
// Holds one element and one read-chain stage. Data moves one cell toward
// the tail or the head on a shift, and the read chain moves toward cell 0.
// ----------------------------------------------------------------------------
module bdl_cell
  import bdl_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  idx_t       idx_i,
  input  elem_t      prev_data_i,
  input  elem_t      next_data_i,
  input  elem_t      next_rd_i,
  output elem_t      data_o,
  output elem_t      rd_o
);

  elem_t data_q;
  elem_t rd_q;

  // Element register: shift, targeted write or hold.
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      CELL_SHIFT_UP:   data_q <= prev_data_i;
      CELL_SHIFT_DOWN: data_q <= next_data_i;
      CELL_WRITE: begin
        if (ctrl_i.wr_idx == idx_i) begin
          data_q <= ctrl_i.wr_data;
        end
      end
      default:         data_q <= data_q;
    endcase
  end

  // Read-chain register: snapshot of the element, then shifts toward the head.
  always_ff @(posedge clk_i) begin
    case (ctrl_i.rd_op)
      RD_LOAD:  rd_q <= data_q;
      RD_SHIFT: rd_q <= next_rd_i;
      default:  rd_q <= rd_q;
    endcase
  end

  assign data_o = data_q;
  assign rd_o   = rd_q;

endmodule

// ===== design/bdl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded double-ended list: port checker
// Watches the top-level ports for command and result timing and for result
// values that the status code rules out.
// ----------------------------------------------------------------------------
module bdl_checker
  import bdl_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [2:0]  command_i,
  input logic        done_o,
  input logic [31:0] read_value_o,
  input logic [1:0]  status_o
);

  // A command that is not a read gives its result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i != CMD_RD_INDEX && command_i != CMD_RD_HEAD &&
     command_i != CMD_RD_TAIL) |=> done_o)
    else $error("non-read command gave no result in the next cycle");

  // A result with an error status carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_FULL || status_o == ST_MISS)) |-> (read_value_o == '0))
    else $error("result with error status carries a value");

  // No result is shown while a read is still in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // A read that starts walking the chain holds back its result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> !done_o)
    else $error("result shown as a read started");

endmodule

bind bounded_double_ended_list_top bdl_checker u_bdl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .command_i    (command_i),
  .done_o       (done_o),
  .read_value_o (read_value_o),
  .status_o     (status_o)
);

// ===== tb/sv/bounded_double_ended_list_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded double-ended list: testbench
// Sends insert, remove and read commands through the start/busy port with
// random idle bursts. A ring-buffer model of the list predicts every result
// (element read, status, length), and each done_o strobe is checked against
// the oldest prediction. Stimulus fills the list to capacity, drains it to
// empty, and mixes in reads at random positions in between.
// ----------------------------------------------------------------------------
module bounded_double_ended_list_top_tb;
  import bdl_pkg::*;

  // The three-bit command field has one code with no operation.
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int RANDOM_CMDS = 1300;
  // Idle bursts stop once this few commands are left to send.
  localparam int QUIET_TAIL  = 100;
  // The slowest result is a tail read of a full list.
  localparam int DRAIN_CYCLES = CAPACITY + 40;
  localparam int TIMEOUT_NS   = 6_000_000;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic [2:0]  code;
    logic [31:0] value;
    logic [7:0]  pos;
  } list_cmd_t;

  typedef struct {
    logic [31:0] value;
    status_e     status;
    logic [8:0]  length;
  } list_result_t;

  typedef enum {GROW, SHRINK, CHURN} mix_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  command_i = CMD_INS_HEAD;
  logic [31:0] element_i = '0;
  logic [7:0]  position_i = '0;
  logic        done_o;
  logic [31:0] read_value_o;
  logic [1:0]  status_o;
  logic [8:0]  length_o;

  // Commands waiting to be sent, and results still owed by the block.
  list_cmd_t    cmd_queue[$];
  list_result_t owed_results[$];
  list_cmd_t    cur_cmd;
  int           cmd_total = 0;
  int           sent_cmds = 0;
  int           gap_left = 0;
  logic         idle_on = 1'b1;

  // Shadow count used while generating commands.
  int           gen_fill = 0;

  // List model state.
  elem_t        list_mem[CAPACITY];
  int           head_ptr = 0;
  int           fill_cnt = 0;
  int           peak_fill = 0;
  int           full_drops = 0;
  int           failed_reads = 0;

  int           checked = 0;
  int           mismatches = 0;
  int           strays = 0;

  bounded_double_ended_list_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (command_i),
    .element_i    (element_i),
    .position_i   (position_i),
    .done_o       (done_o),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .length_o     (length_o)
  );

  always #2 clk_i = ~clk_i;

  // Apply one command to the list model and return the result it owes.
  function automatic list_result_t list_apply(input list_cmd_t c);
    list_result_t r;
    r.value  = '0;
    r.status = ST_OK;
    case (c.code)
      CMD_INS_HEAD: begin
        if (fill_cnt >= CAPACITY) begin
          r.status = ST_FULL;
          full_drops++;
        end else begin
          head_ptr = (head_ptr + CAPACITY - 1) % CAPACITY;
          list_mem[head_ptr] = c.value;
          fill_cnt++;
        end
      end
      CMD_INS_TAIL: begin
        if (fill_cnt >= CAPACITY) begin
          r.status = ST_FULL;
          full_drops++;
        end else begin
          list_mem[(head_ptr + fill_cnt) % CAPACITY] = c.value;
          fill_cnt++;
        end
      end
      CMD_REM_HEAD: begin
        if (fill_cnt > 0) begin
          head_ptr = (head_ptr + 1) % CAPACITY;
          fill_cnt--;
        end
      end
      CMD_REM_TAIL: begin
        if (fill_cnt > 0) fill_cnt--;
      end
      CMD_RD_INDEX: begin
        if (int'(c.pos) < fill_cnt) begin
          r.value = list_mem[(head_ptr + int'(c.pos)) % CAPACITY];
        end else begin
          r.status = ST_MISS;
          failed_reads++;
        end
      end
      CMD_RD_HEAD: begin
        if (fill_cnt > 0) begin
          r.value = list_mem[head_ptr];
        end else begin
          r.status = ST_MISS;
          failed_reads++;
        end
      end
      CMD_RD_TAIL: begin
        if (fill_cnt > 0) begin
          r.value = list_mem[(head_ptr + fill_cnt - 1) % CAPACITY];
        end else begin
          r.status = ST_MISS;
          failed_reads++;
        end
      end
      default: begin
      end
    endcase
    if (fill_cnt > peak_fill) peak_fill = fill_cnt;
    r.length = fill_cnt[8:0];
    return r;
  endfunction

  // Queue one command and track the count it leaves behind.
  function automatic void queue_cmd(input logic [2:0] code, input logic [31:0] value,
                                    input logic [7:0] pos);
    list_cmd_t c;
    c.code  = code;
    c.value = value;
    c.pos   = pos;
    cmd_queue.push_back(c);
    cmd_total++;
    if ((code == CMD_INS_HEAD || code == CMD_INS_TAIL) && gen_fill < CAPACITY) gen_fill++;
    if ((code == CMD_REM_HEAD || code == CMD_REM_TAIL) && gen_fill > 0) gen_fill--;
  endfunction

  function automatic logic [31:0] pick_element();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Read positions mostly fall inside the list, some on its edges or beyond.
  function automatic logic [7:0] pick_position();
    int k;
    k = $urandom_range(0, 9);
    if (gen_fill == 0 || k == 2) return 8'($urandom_range(0, 255));
    if (k == 0) return 8'(gen_fill);
    if (k == 1) return 8'(gen_fill - 1);
    return 8'($urandom_range(0, gen_fill - 1));
  endfunction

  // Put the next command on the port.
  task automatic present_cmd(input list_cmd_t c);
    start      <= 1'b1;
    command_i  <= c.code;
    element_i  <= c.value;
    position_i <= c.pos;
  endtask

  // Driver: one transfer per start & !busy edge, with random idle bursts.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        owed_results.push_back(list_apply(cur_cmd));
        sent_cmds++;
        if (idle_on && cmd_queue.size() > QUIET_TAIL && $urandom_range(0, 3) == 0) begin
          start      <= 1'b0;
          gap_left   <= $urandom_range(1, 9) - 1;
          command_i  <= 3'($urandom);
          element_i  <= $urandom;
          position_i <= 8'($urandom);
        end else if (cmd_queue.size() != 0) begin
          cur_cmd = cmd_queue.pop_front();
          present_cmd(cur_cmd);
        end else begin
          start <= 1'b0;
        end
        if ($urandom_range(0, 47) == 0) idle_on <= !idle_on;
      end else if (!start) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (cmd_queue.size() != 0) begin
          cur_cmd = cmd_queue.pop_front();
          present_cmd(cur_cmd);
        end
      end
    end
  end

  // Monitor: every done_o strobe is matched with the oldest owed result.
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && done_o) begin
      if (owed_results.size() == 0) begin
        strays++;
        if (mismatches + strays <= REPORT_LIMIT)
          $display("%0t: result with nothing outstanding: value %h status %0d length %0d",
                   $realtime, read_value_o, status_o, length_o);
      end else begin
        want = owed_results.pop_front();
        checked++;
        if (read_value_o !== want.value || status_o !== want.status ||
            length_o !== want.length) begin
          mismatches++;
          if (mismatches + strays <= REPORT_LIMIT)
            $display("%0t: result %0d: expected value %h status %0d length %0d, got %h %0d %0d",
                     $realtime, checked, want.value, want.status, want.length,
                     read_value_o, status_o, length_o);
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    mix_e        mix;
    int          phase_left;
    int          made;
    int          extra;
    int          r;
    logic [2:0]  code;

    // Directed part: empty-list cases, unused code, field extremes, edges.
    queue_cmd(CMD_RD_HEAD,  $urandom, 8'($urandom));
    queue_cmd(CMD_RD_TAIL,  $urandom, 8'($urandom));
    queue_cmd(CMD_RD_INDEX, $urandom, 8'd0);
    queue_cmd(CMD_REM_HEAD, $urandom, 8'($urandom));
    queue_cmd(CMD_REM_TAIL, $urandom, 8'($urandom));
    queue_cmd(CMD_UNUSED,   '1,       8'hff);
    queue_cmd(CMD_INS_TAIL, '1,       8'($urandom));
    queue_cmd(CMD_INS_HEAD, '0,       8'($urandom));
    queue_cmd(CMD_INS_TAIL, 32'ha5a5_5a5a, 8'($urandom));
    queue_cmd(CMD_INS_HEAD, 32'h8000_0001, 8'($urandom));
    queue_cmd(CMD_RD_HEAD,  $urandom, 8'($urandom));
    queue_cmd(CMD_RD_TAIL,  $urandom, 8'($urandom));
    queue_cmd(CMD_RD_INDEX, $urandom, 8'd0);
    queue_cmd(CMD_RD_INDEX, $urandom, 8'd3);
    queue_cmd(CMD_RD_INDEX, $urandom, 8'd4);
    queue_cmd(CMD_RD_INDEX, $urandom, 8'hff);
    queue_cmd(CMD_UNUSED,   $urandom, 8'($urandom));
    queue_cmd(CMD_REM_HEAD, $urandom, 8'($urandom));
    queue_cmd(CMD_RD_HEAD,  $urandom, 8'($urandom));
    queue_cmd(CMD_REM_TAIL, $urandom, 8'($urandom));
    queue_cmd(CMD_RD_TAIL,  $urandom, 8'($urandom));
    queue_cmd(CMD_REM_HEAD, $urandom, 8'($urandom));
    queue_cmd(CMD_REM_TAIL, $urandom, 8'($urandom));
    queue_cmd(CMD_REM_TAIL, $urandom, 8'($urandom));

    // Random part: churn, grow to full, churn, shrink to empty, and again.
    mix = CHURN;
    phase_left = $urandom_range(40, 150);
    extra = 0;
    for (made = 0; made < RANDOM_CMDS; made++) begin
      r = $urandom_range(0, 99);
      case (mix)
        GROW:    code = (r < 75) ? CMD_INS_HEAD : (r < 82) ? CMD_REM_HEAD :
                        (r < 97) ? CMD_RD_INDEX : CMD_UNUSED;
        SHRINK:  code = (r < 12) ? CMD_INS_HEAD : (r < 75) ? CMD_REM_HEAD :
                        (r < 97) ? CMD_RD_INDEX : CMD_UNUSED;
        default: code = (r < 35) ? CMD_INS_HEAD : (r < 60) ? CMD_REM_HEAD :
                        (r < 97) ? CMD_RD_INDEX : CMD_UNUSED;
      endcase
      // Pick the head or tail flavor of the chosen kind.
      if (code == CMD_INS_HEAD && $urandom_range(0, 1)) code = CMD_INS_TAIL;
      if (code == CMD_REM_HEAD && $urandom_range(0, 1)) code = CMD_REM_TAIL;
      if (code == CMD_RD_INDEX) begin
        r = $urandom_range(0, 3);
        if (r == 1) code = CMD_RD_HEAD;
        if (r == 2) code = CMD_RD_TAIL;
      end
      queue_cmd(code, pick_element(), (code == CMD_RD_INDEX) ? pick_position()
                                                             : 8'($urandom));
      // Phase changes: growth and shrink phases run past full and empty.
      case (mix)
        GROW: begin
          if (gen_fill == CAPACITY && extra == 0) extra = $urandom_range(4, 16);
          if (extra != 0 && --extra == 0) begin
            mix = CHURN;
            phase_left = $urandom_range(40, 150);
          end
        end
        SHRINK: begin
          if (gen_fill == 0 && extra == 0) extra = $urandom_range(4, 16);
          if (extra != 0 && --extra == 0) begin
            mix = CHURN;
            phase_left = $urandom_range(40, 150);
          end
        end
        default: begin
          if (--phase_left == 0) mix = (gen_fill > CAPACITY / 2) ? SHRINK : GROW;
        end
      endcase
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sent_cmds < cmd_total) @(posedge clk_i);
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d commands and checked %0d results; peak fill %0d of %0d.",
             sent_cmds, checked, peak_fill, CAPACITY);
    $display("Saw %0d inserts dropped on a full list and %0d reads that missed.",
             full_drops, failed_reads);
    if (mismatches == 0 && strays == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results with nothing outstanding", mismatches, strays);
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog for a block that stops answering.
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d commands sent and %0d results owed",
             sent_cmds, owed_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
